[src/m4vt_pkg.sv]
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants for the 4x4 matrix-vector transform block.
// ----------------------------------------------------------------------------
package m4vt_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAT_DIM     = 4;
   localparam int MAT_SIZE    = MAT_DIM * MAT_DIM;
   localparam int IDX_W       = 2;
   localparam int ELEM_W      = 32;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_XFORM = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef logic signed [ELEM_W-1:0] elem_type;

   // queued item: data[0] holds the element for a write, data[0..3] the vector
   typedef struct packed {
      kind_type               op;
      logic [IDX_W-1:0]       row;
      logic [IDX_W-1:0]       col;
      logic [MAT_DIM-1:0][ELEM_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   localparam elem_type UNIT_ELEM = elem_type'(1 << FRAC_BITS);

endpackage

[src/m4vt_front.sv]
// ----------------------------------------------------------------------------
// m4vt_front
// Accepts request items, decodes the kind and packs them for the queue.
// ----------------------------------------------------------------------------
module m4vt_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [1:0]                req_row,
   input  logic [1:0]                req_col,
   input  logic signed [31:0]        req_elem_value,
   input  logic signed [31:0]        req_vec_x,
   input  logic signed [31:0]        req_vec_y,
   input  logic signed [31:0]        req_vec_z,
   input  logic signed [31:0]        req_vec_w,
   input  m4vt_pkg::qstat_type       q_stat,
   output logic                      push,
   output m4vt_pkg::entry_type       push_entry
);
   import m4vt_pkg::*;

   kind_type kind;

   assign kind      = kind_type'(req_kind);
   assign req_stall = q_stat.full;
   // unused kind is taken and dropped here
   assign push      = req_valid && !q_stat.full && (kind != KIND_NONE);

   always_comb begin
      push_entry     = '0;
      push_entry.op  = kind;
      push_entry.row = req_row;
      push_entry.col = req_col;
      if (kind == KIND_WRITE) begin
         push_entry.data[0] = req_elem_value;
      end else begin
         push_entry.data[0] = req_vec_x;
         push_entry.data[1] = req_vec_y;
         push_entry.data[2] = req_vec_z;
         push_entry.data[3] = req_vec_w;
      end
   end

endmodule

[src/m4vt_queue.sv]
// ----------------------------------------------------------------------------
// m4vt_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module m4vt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  m4vt_pkg::entry_type push_entry,
   input  logic                pop,
   output m4vt_pkg::entry_type head,
   output m4vt_pkg::qstat_type q_stat
);
   import m4vt_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

[src/m4vt_back.sv]
// ----------------------------------------------------------------------------
// m4vt_back
// Holds the matrix, applies writes in order and runs the multiply pipeline:
// products, row sums, then shift, saturate and the result register.
// ----------------------------------------------------------------------------
module m4vt_back (
   input  logic                clock,
   input  logic                reset,
   input  m4vt_pkg::entry_type head,
   input  m4vt_pkg::qstat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_read_elem,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic signed [31:0]  rsp_out_w
);
   import m4vt_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      SUM_W'(elem_type'({1'b0, {(ELEM_W-1){1'b1}}}));
   localparam logic signed [SUM_W-1:0] SAT_LO =
      SUM_W'(elem_type'({1'b1, {(ELEM_W-1){1'b0}}}));

   elem_type                   mat_ff [MAT_SIZE];
   logic [IDX_W*2-1:0]         head_idx;

   // product stage
   logic                       s1_valid_ff;
   kind_type                   s1_op_ff;
   elem_type                   s1_elem_ff;
   logic signed [PROD_W-1:0]   s1_prod_ff [MAT_DIM][MAT_DIM];
   logic signed [PROD_W-1:0]   prod_in    [MAT_DIM][MAT_DIM];

   // sum stage
   logic                       s2_valid_ff;
   kind_type                   s2_op_ff;
   elem_type                   s2_elem_ff;
   logic signed [SUM_W-1:0]    s2_sum_ff [MAT_DIM];
   logic signed [SUM_W-1:0]    sum_in    [MAT_DIM];

   // result register
   logic                       out_valid_ff;
   elem_type                   out_read_ff;
   elem_type                   out_dot_ff [MAT_DIM];
   elem_type                   sat_in     [MAT_DIM];
   logic signed [SUM_W-1:0]    shifted    [MAT_DIM];

   logic move_out, move_s2, s1_free, s2_free, head_is_write, load_s1;

   assign move_out      = s2_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s2_free       = !s2_valid_ff || move_out;
   assign move_s2       = s1_valid_ff && s2_free;
   assign s1_free       = !s1_valid_ff || move_s2;
   assign head_is_write = (head.op == KIND_WRITE);
   // writes take no pipeline slot; everything ahead has already read the matrix
   assign pop           = !q_stat.empty && (head_is_write || s1_free);
   assign load_s1       = pop && !head_is_write;
   assign head_idx      = {head.row, head.col};

   always_comb begin
      for (int r = 0; r < MAT_DIM; r++) begin
         for (int c = 0; c < MAT_DIM; c++) begin
            prod_in[r][c] = mat_ff[r*MAT_DIM + c] * $signed(head.data[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < MAT_DIM; r++) begin
         sum_in[r] = SUM_W'(s1_prod_ff[r][0]) + SUM_W'(s1_prod_ff[r][1])
                   + SUM_W'(s1_prod_ff[r][2]) + SUM_W'(s1_prod_ff[r][3]);
      end
   end

   // arithmetic shift floors, then clamp to the 32-bit range
   always_comb begin
      for (int r = 0; r < MAT_DIM; r++) begin
         shifted[r] = s2_sum_ff[r] >>> FRAC_BITS;
         if (shifted[r] > SAT_HI) begin
            sat_in[r] = elem_type'(SAT_HI[ELEM_W-1:0]);
         end else if (shifted[r] < SAT_LO) begin
            sat_in[r] = elem_type'(SAT_LO[ELEM_W-1:0]);
         end else begin
            sat_in[r] = shifted[r][ELEM_W-1:0];
         end
      end
   end

   // matrix, reset to identity
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_SIZE; i++) begin
            mat_ff[i] <= ((i / MAT_DIM) == (i % MAT_DIM)) ? UNIT_ELEM : '0;
         end
      end else if (pop && head_is_write) begin
         mat_ff[head_idx] <= $signed(head.data[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= load_s1;
         end
         if (s2_free) begin
            s2_valid_ff <= move_s2;
         end
         if (!out_valid_ff || !rsp_stall) begin
            out_valid_ff <= move_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_op_ff   <= head.op;
         s1_elem_ff <= mat_ff[head_idx];
         s1_prod_ff <= prod_in;
      end
      if (move_s2) begin
         s2_op_ff   <= s1_op_ff;
         s2_elem_ff <= s1_elem_ff;
         s2_sum_ff  <= sum_in;
      end
      if (move_out) begin
         out_read_ff <= (s2_op_ff == KIND_READ) ? s2_elem_ff : '0;
         for (int r = 0; r < MAT_DIM; r++) begin
            out_dot_ff[r] <= (s2_op_ff == KIND_XFORM) ? sat_in[r] : '0;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_elem = out_read_ff;
   assign rsp_out_x     = out_dot_ff[0];
   assign rsp_out_y     = out_dot_ff[1];
   assign rsp_out_z     = out_dot_ff[2];
   assign rsp_out_w     = out_dot_ff[3];

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !move_s2 |=> s1_valid_ff)
      else $error("product stage lost an item");

   a_read_zero_dots: assert property (@(posedge clock) disable iff (reset)
      move_out && (s2_op_ff == KIND_READ) |=>
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && rsp_out_w == '0)
      else $error("read result carries dot products");

   a_xform_zero_read: assert property (@(posedge clock) disable iff (reset)
      move_out && (s2_op_ff == KIND_XFORM) |=> rsp_read_elem == '0)
      else $error("transform result carries a read element");

endmodule

[src/matrix4_vector_transform.sv]
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// 4x4 signed Q16.16 matrix with element write, element read and
// matrix-vector transform.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while req_stall is low and gives
// one read or transform result per cycle while rsp_stall is low. Items
// pass through a four-entry queue; an item that leaves it passes the
// product register, the sum register and then the result register. The
// sixteen 32x32 products are formed in parallel row lanes in one stage,
// the row sums in the next, and the shift and saturation feed the result
// register. Element writes occupy a queue slot but no pipeline stage and
// give no result; kind 3 is taken and dropped. req_stall rises only while
// the queue is full, which happens when rsp_stall holds the pipeline.
// The matrix resets to identity at once; no clearing pass is needed.
module matrix4_vector_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [1:0]         req_row,
   input  logic [1:0]         req_col,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_vec_w,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_elem,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_w
);
   import m4vt_pkg::*;

   logic      push, pop;
   entry_type push_entry, head;
   qstat_type q_stat;

   m4vt_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_elem_value (req_elem_value),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_vec_z      (req_vec_z),
      .req_vec_w      (req_vec_w),
      .q_stat         (q_stat),
      .push           (push),
      .push_entry     (push_entry)
   );

   m4vt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   m4vt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_stat        (q_stat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_elem (rsp_read_elem),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w)
   );

endmodule
